>>> design/psi_pkg.sv
// Package for the pressure safety interlock: opcodes, trip causes,
// register indexes, reset values and the structs used by the design modules.
// No dependencies.
package psi_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_MARK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_ESTOP_PRESSURE = 2'd0,
        REG_ESTOP_HOLD_MS  = 2'd1,
        REG_TRIP_PRESSURE  = 2'd2,
        REG_BLINK_MS       = 2'd3
    } reg_idx_t;

    localparam logic [1:0] CAUSE_NONE      = 2'd0;
    localparam logic [1:0] CAUSE_THRESHOLD = 2'd1;
    localparam logic [1:0] CAUSE_AT_LIMIT  = 2'd2;
    localparam logic [1:0] CAUSE_ESTOP     = 2'd3;

    localparam logic [15:0] RST_ESTOP_PRESSURE = 16'd23000;
    localparam logic [15:0] RST_ESTOP_HOLD_MS  = 16'd10000;
    localparam logic [15:0] RST_TRIP_PRESSURE  = 16'd25000;
    localparam logic [15:0] RST_BLINK_MS       = 16'd500;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] estop_pressure;
        logic [15:0] estop_hold_ms;
        logic [15:0] trip_pressure;
        logic [15:0] blink_ms;
    } cfg_t;

    typedef struct packed {
        op_t         opcode;
        logic [15:0] pressure_tenths;
        logic        at_limit;
    } item_t;

    typedef struct packed {
        logic        safety_latch;
        logic        estop_latch;
        logic        engine_stopped;
        logic        high_active;
        logic [15:0] high_elapsed;
        logic [15:0] blink_elapsed;
        logic        lamp_state;
        logic        limit_used;
        logic [1:0]  cause;
    } state_t;

    typedef struct packed {
        logic       high_timing;
        logic [1:0] trip_cause;
        logic       lamp_on;
        logic       engine_off;
        logic       estop_on;
        logic       safety_on;
    } result_t;

endpackage

>>> design/psi_cfg_regs.sv
// Configuration register file for the pressure safety interlock.
// Depends on psi_pkg for register indexes, reset values and cfg_t.
module psi_cfg_regs
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [1:0]           wr_index,
    input  logic [15:0]          wr_data,
    output psi_pkg::cfg_t        cfg
);

    psi_pkg::cfg_t cfg_reg;
    psi_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (psi_pkg::reg_idx_t'(wr_index))
                psi_pkg::REG_ESTOP_PRESSURE: cfg_next.estop_pressure = wr_data;
                psi_pkg::REG_ESTOP_HOLD_MS:  cfg_next.estop_hold_ms  = wr_data;
                psi_pkg::REG_TRIP_PRESSURE:  cfg_next.trip_pressure  = wr_data;
                psi_pkg::REG_BLINK_MS:       cfg_next.blink_ms       = wr_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.estop_pressure <= psi_pkg::RST_ESTOP_PRESSURE;
            cfg_reg.estop_hold_ms  <= psi_pkg::RST_ESTOP_HOLD_MS;
            cfg_reg.trip_pressure  <= psi_pkg::RST_TRIP_PRESSURE;
            cfg_reg.blink_ms       <= psi_pkg::RST_BLINK_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/psi_core.sv
// Interlock state and its single-pass update for one request.
// Depends on psi_pkg for op_t, cfg_t, item_t, state_t and result_t.
module psi_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  psi_pkg::item_t    item,
    input  psi_pkg::cfg_t     cfg,
    output psi_pkg::result_t  result
);

    psi_pkg::state_t st_reg;
    psi_pkg::state_t st_next;

    always_comb
    begin
        st_next = st_reg;
        unique case (item.opcode)
            psi_pkg::OP_SAMPLE:
            begin
                if (item.pressure_tenths >= cfg.estop_pressure)
                begin
                    if (!st_reg.high_active)
                    begin
                        st_next.high_active  = 1'b1;
                        st_next.high_elapsed = '0;
                    end
                    else if (st_reg.high_elapsed >= cfg.estop_hold_ms && !st_reg.estop_latch)
                    begin
                        st_next.estop_latch    = 1'b1;
                        st_next.safety_latch   = 1'b1;
                        st_next.cause          = psi_pkg::CAUSE_ESTOP;
                        st_next.engine_stopped = 1'b1;
                    end
                end
                else
                begin
                    st_next.high_active  = 1'b0;
                    st_next.high_elapsed = '0;
                end

                // trip only when not already latched; keep the earlier cause
                if (item.pressure_tenths >= cfg.trip_pressure && !st_next.safety_latch)
                begin
                    st_next.safety_latch   = 1'b1;
                    st_next.cause          = item.at_limit ? psi_pkg::CAUSE_AT_LIMIT
                                                           : psi_pkg::CAUSE_THRESHOLD;
                    st_next.engine_stopped = 1'b1;
                end

                if (st_next.safety_latch || st_next.estop_latch)
                begin
                    st_next.lamp_state = 1'b1;
                end
                else if (st_reg.limit_used)
                begin
                    if (st_reg.blink_elapsed >= cfg.blink_ms)
                    begin
                        st_next.lamp_state    = !st_reg.lamp_state;
                        st_next.blink_elapsed = '0;
                    end
                end
                else
                begin
                    st_next.lamp_state = 1'b0;
                end
            end
            psi_pkg::OP_TICK:
            begin
                if (st_reg.high_active && st_reg.high_elapsed != psi_pkg::COUNT_MAX)
                begin
                    st_next.high_elapsed = st_reg.high_elapsed + 16'd1;
                end
                if (st_reg.blink_elapsed != psi_pkg::COUNT_MAX)
                begin
                    st_next.blink_elapsed = st_reg.blink_elapsed + 16'd1;
                end
            end
            psi_pkg::OP_CLEAR:
            begin
                if (st_reg.estop_latch)
                begin
                    st_next.estop_latch  = 1'b0;
                    st_next.high_active  = 1'b0;
                    st_next.high_elapsed = '0;
                end
                if (st_reg.safety_latch)
                begin
                    st_next.safety_latch   = 1'b0;
                    st_next.cause          = psi_pkg::CAUSE_NONE;
                    st_next.engine_stopped = 1'b0;
                end
            end
            psi_pkg::OP_MARK:
            begin
                st_next.limit_used = 1'b1;
            end
            default:
            begin
                st_next = st_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (step)
        begin
            st_reg <= st_next;
        end
    end

    always_comb
    begin
        result.safety_on   = st_next.safety_latch;
        result.estop_on    = st_next.estop_latch;
        result.engine_off  = st_next.engine_stopped;
        result.lamp_on     = st_next.lamp_state;
        result.trip_cause  = st_next.cause;
        result.high_timing = st_next.high_active;
    end

    a_estop_implies_safety: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.estop_latch |-> st_reg.safety_latch)
        else $error("e-stop latched without safety latch");

    a_engine_tracks_safety: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.engine_stopped == st_reg.safety_latch)
        else $error("engine state disagrees with safety latch");

    a_cause_tracks_safety: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.cause != psi_pkg::CAUSE_NONE) == st_reg.safety_latch)
        else $error("trip cause disagrees with safety latch");

    a_hold_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && $past(!st_reg.high_active) && !st_reg.high_active) |->
            st_reg.high_elapsed == '0)
        else $error("hold timer counted while idle");

endmodule

>>> design/pressure_safety_interlock_top.sv
// Top level of the pressure safety interlock: input register, output register
// and the instances of psi_cfg_regs and psi_core. Depends on psi_pkg.
//
// Pressure safety interlock. Each request carries an opcode in s_tuser (sample,
// millisecond tick, clear, mark limit used) and yields exactly one status result.
// The block takes one request per clock cycle while the output is not stalled.
// A request is first held in the input register and its result then in the output
// register; m_tvalid rises once the result is in the output register. The single
// state update in psi_core evaluates one request per unstalled cycle between the
// input register and the output register. Configuration writes take effect on
// the next request and should be issued while no request is in flight.
module pressure_safety_interlock_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] pressure_tenths, [16] at_limit, [23:17] zero
    input  logic [1:0]  s_tuser,   // [1:0] opcode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] safety_on, [1] estop_on, [2] engine_off,
                                   // [3] lamp_on, [5:4] trip_cause, [6] high_timing, [7] zero

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic              in_valid_reg;
    logic              in_valid_next;
    psi_pkg::item_t    in_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    psi_pkg::result_t  out_res_reg;
    psi_pkg::cfg_t     cfg;
    psi_pkg::result_t  core_res;
    logic              out_free;
    logic              step;

    assign cfg_ready = 1'b1;

    psi_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // advance the output register when it is empty or being drained
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.opcode          <= psi_pkg::op_t'(s_tuser);
            in_item_reg.pressure_tenths <= s_tdata[15:0];
            in_item_reg.at_limit        <= s_tdata[16];
        end
        if (step)
        begin
            out_res_reg <= core_res;
        end
    end

    psi_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg};

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !step)
        else $error("state advanced while output was blocked");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input not ready while input register empty");

endmodule

>>> bench/psi_interlock_checker.sv
`timescale 1ns / 100ps
// Status checker for the pressure safety interlock: watches the request, result
// and register write channels, predicts each status word and compares it.
// Depends on psi_pkg for opcodes, causes and register reset values.
module psi_interlock_checker
    import psi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] pressure_tenths, [16] at_limit, [23:17] zero
    input  logic [1:0]  s_tuser,   // [1:0] opcode

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [0] safety_on, [1] estop_on, [2] engine_off,
                                   // [3] lamp_on, [5:4] trip_cause, [6] high_timing

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    output int          mismatches,
    output int          pending,
    output int          results_checked,
    output int          estop_count,
    output int          trip_count
);

    typedef struct packed {
        logic       safety;
        logic       estop;
        logic       engine;
        logic       lamp;
        logic [1:0] cause;
        logic       timing;
    } status_t;

    // register copies
    logic [15:0] lvl_estop;
    logic [15:0] hold_limit;
    logic [15:0] lvl_trip;
    logic [15:0] blink_period;

    // interlock state
    logic        safety_set;
    logic        estop_set;
    logic        engine_halted;
    logic        hold_running;
    logic [15:0] hold_count;
    logic [15:0] blink_count;
    logic        lamp_level;
    logic        limit_flag;
    logic [1:0]  cause_code;

    status_t     status_q[$];

    function automatic logic [15:0] sat_step(logic [15:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + 16'd1;
    endfunction

    task automatic clear_interlock();
        lvl_estop     = RST_ESTOP_PRESSURE;
        hold_limit    = RST_ESTOP_HOLD_MS;
        lvl_trip      = RST_TRIP_PRESSURE;
        blink_period  = RST_BLINK_MS;
        safety_set    = 1'b0;
        estop_set     = 1'b0;
        engine_halted = 1'b0;
        hold_running  = 1'b0;
        hold_count    = '0;
        blink_count   = '0;
        lamp_level    = 1'b0;
        limit_flag    = 1'b0;
        cause_code    = CAUSE_NONE;
    endtask

    task automatic release_safety();
        if (safety_set)
        begin
            safety_set    = 1'b0;
            cause_code    = CAUSE_NONE;
            engine_halted = 1'b0;
        end
    endtask

    task automatic take_sample(logic [15:0] p, logic lim);
        if (p >= lvl_estop)
        begin
            if (!hold_running)
            begin
                hold_running = 1'b1;
                hold_count   = '0;
            end
            else if (hold_count >= hold_limit && !estop_set)
            begin
                estop_set     = 1'b1;
                safety_set    = 1'b1;
                cause_code    = CAUSE_ESTOP;
                engine_halted = 1'b1;
                estop_count++;
            end
        end
        else
        begin
            hold_running = 1'b0;
            hold_count   = '0;
        end

        if (p >= lvl_trip && !safety_set)
        begin
            safety_set    = 1'b1;
            cause_code    = lim ? CAUSE_AT_LIMIT : CAUSE_THRESHOLD;
            engine_halted = 1'b1;
            trip_count++;
        end

        // solid when latched, blink once the limit was used, else dark
        if (safety_set || estop_set)
            lamp_level = 1'b1;
        else if (limit_flag)
        begin
            if (blink_count >= blink_period)
            begin
                lamp_level  = !lamp_level;
                blink_count = '0;
            end
        end
        else
            lamp_level = 1'b0;
    endtask

    function automatic status_t interlock_status();
        status_t s;
        s.safety = safety_set;
        s.estop  = estop_set;
        s.engine = engine_halted;
        s.lamp   = lamp_level;
        s.cause  = cause_code;
        s.timing = hold_running;
        return s;
    endfunction

    task automatic apply_request(op_t op, logic [15:0] p, logic lim);
        case (op)
            OP_SAMPLE: take_sample(p, lim);
            OP_TICK:
            begin
                if (hold_running)
                    hold_count = sat_step(hold_count);
                blink_count = sat_step(blink_count);
            end
            OP_CLEAR:
            begin
                if (estop_set)
                begin
                    estop_set    = 1'b0;
                    hold_running = 1'b0;
                    hold_count   = '0;
                end
                release_safety();
            end
            default: limit_flag = 1'b1;
        endcase
    endtask

    task automatic apply_write(reg_idx_t idx, logic [15:0] v);
        case (idx)
            REG_ESTOP_PRESSURE: lvl_estop    = v;
            REG_ESTOP_HOLD_MS:  hold_limit   = v;
            REG_TRIP_PRESSURE:  lvl_trip     = v;
            default:            blink_period = v;
        endcase
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        status_t want;
        if (!rst_n)
        begin
            clear_interlock();
            status_q.delete();
            mismatches      = 0;
            results_checked = 0;
            estop_count     = 0;
            trip_count      = 0;
            pending        <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_write(reg_idx_t'(cfg_index), cfg_data);

            if (s_tvalid && s_tready)
            begin
                apply_request(op_t'(s_tuser), s_tdata[15:0], s_tdata[16]);
                status_q.push_back(interlock_status());
            end

            if (m_tvalid && m_tready)
            begin
                if (status_q.size() == 0)
                begin
                    $error("status result with no request outstanding: %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = status_q.pop_front();
                    check_field("safety_on",   int'(want.safety), int'(m_tdata[0]));
                    check_field("estop_on",    int'(want.estop),  int'(m_tdata[1]));
                    check_field("engine_off",  int'(want.engine), int'(m_tdata[2]));
                    check_field("lamp_on",     int'(want.lamp),   int'(m_tdata[3]));
                    check_field("trip_cause",  int'(want.cause),  int'(m_tdata[5:4]));
                    check_field("high_timing", int'(want.timing), int'(m_tdata[6]));
                    results_checked++;
                end
            end

            pending <= status_q.size();
        end
    end

endmodule

>>> bench/tb_pressure_safety_interlock_top.sv
`timescale 1ns / 100ps
// Testbench top for the pressure safety interlock: clock, reset, request and
// register stimulus, output stalls and the verdict.
// Depends on psi_pkg, pressure_safety_interlock_top and psi_interlock_checker.
module tb_pressure_safety_interlock_top;

    import psi_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [15:0] pressure_tenths, [16] at_limit, [23:17] zero
    logic [1:0]  s_tuser;    // [1:0] opcode

    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [0] safety_on, [1] estop_on, [2] engine_off,
                             // [3] lamp_on, [5:4] trip_cause, [6] high_timing, [7] zero

    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int          mismatches;
    int          pending;
    int          results_checked;
    int          estop_count;
    int          trip_count;

    int          sent_count = 0;
    int          settings_used = 1;
    int          burst_left = 0;
    bit          fast = 1'b0;
    logic [15:0] cur_estop = RST_ESTOP_PRESSURE;
    logic [15:0] cur_trip  = RST_TRIP_PRESSURE;

    always #6 clk = ~clk;

    pressure_safety_interlock_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    psi_interlock_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .estop_count     (estop_count),
        .trip_count      (trip_count)
    );

    // Offer one request; valid stays high after acceptance so a burst runs back to back.
    task automatic send(op_t op, logic [15:0] p, logic lim);
        int gap_len;
        if (!fast)
        begin
            if (burst_left == 0)
            begin
                gap_len = $urandom_range(0, 10);
                if (gap_len > 0)
                begin
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                    repeat (gap_len - 1) @(negedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, lim, p};
        do @(posedge clk); while (!s_tready);
        sent_count++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(reg_idx_t idx, logic [15:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [15:0] lvl_e, logic [15:0] hold, logic [15:0] lvl_t,
                              logic [15:0] blink);
        drain();
        cfg_write(REG_ESTOP_PRESSURE, lvl_e);
        cfg_write(REG_ESTOP_HOLD_MS, hold);
        cfg_write(REG_TRIP_PRESSURE, lvl_t);
        cfg_write(REG_BLINK_MS, blink);
        cur_estop = lvl_e;
        cur_trip  = lvl_t;
        settings_used++;
    endtask

    function automatic logic [15:0] near_level(logic [15:0] lvl);
        int v;
        v = int'(lvl);
        v = v + int'($urandom_range(0, 4)) - 2;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    task automatic random_request();
        int          pick;
        int          psel;
        op_t         op;
        logic [15:0] p;
        pick = $urandom_range(0, 99);
        psel = $urandom_range(0, 99);
        if (pick < 40)
            op = OP_SAMPLE;
        else if (pick < 75)
            op = OP_TICK;
        else if (pick < 87)
            op = OP_CLEAR;
        else
            op = OP_MARK;
        // aim most samples at the two thresholds
        if (psel < 35)
            p = near_level(cur_estop);
        else if (psel < 70)
            p = near_level(cur_trip);
        else
            p = 16'($urandom_range(0, 65535));
        send(op, p, 1'($urandom_range(0, 1)));
    endtask

    // Receiver: stall patterns, plus one long hold-off that backs up the request side.
    initial
    begin
        int mode;
        int span;
        bit held;
        m_tready = 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && sent_count >= 400)
            begin
                held = 1'b1;
                repeat (300)
                begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_SAMPLE;
        cfg_valid = 1'b0;
        cfg_index = REG_ESTOP_PRESSURE;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset register values
        send(OP_SAMPLE, 16'd25000, 1'b1);
        send(OP_TICK, 16'd0, 1'b0);
        send(OP_CLEAR, 16'd0, 1'b0);

        set_config(16'd1000, 16'd2, 16'd2000, 16'd1);
        send(OP_TICK, 16'hFFFF, 1'b1);
        send(OP_CLEAR, 16'hFFFF, 1'b1);
        send(OP_SAMPLE, 16'd0, 1'b0);
        send(OP_SAMPLE, 16'd999, 1'b1);
        send(OP_SAMPLE, 16'd1000, 1'b0);
        send(OP_TICK, 16'd0, 1'b0);
        send(OP_TICK, 16'd0, 1'b0);
        send(OP_SAMPLE, 16'd1000, 1'b0);
        send(OP_SAMPLE, 16'd2000, 1'b1);
        send(OP_CLEAR, 16'd0, 1'b0);
        send(OP_SAMPLE, 16'd2000, 1'b1);
        send(OP_TICK, 16'd0, 1'b0);
        send(OP_TICK, 16'd0, 1'b0);
        send(OP_TICK, 16'd0, 1'b0);
        send(OP_SAMPLE, 16'd1500, 1'b0);
        send(OP_CLEAR, 16'd0, 1'b0);
        send(OP_SAMPLE, 16'hFFFF, 1'b0);
        send(OP_CLEAR, 16'd0, 1'b0);
        send(OP_MARK, 16'h5A5A, 1'b1);
        send(OP_SAMPLE, 16'd0, 1'b0);
        send(OP_TICK, 16'd0, 1'b0);
        send(OP_SAMPLE, 16'd0, 1'b0);
        send(OP_SAMPLE, 16'd0, 1'b0);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_config(16'd1000, 16'd3, 16'd2000, 16'd4);
                1: set_config(16'd0, 16'd0, 16'hFFFF, 16'd0);
                2: set_config(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
                3: set_config(16'($urandom_range(0, 65535)), 16'd1,
                              16'($urandom_range(0, 65535)), 16'd1);
                default: set_config(16'($urandom_range(0, 65535)),
                                    16'($urandom_range(0, 12)),
                                    16'($urandom_range(0, 65535)),
                                    16'($urandom_range(0, 12)));
            endcase
            repeat (200) random_request();
        end

        // Run the hold timer past a longer hold time with ticks back to back.
        set_config(16'd100, 16'd20, 16'hFFFF, 16'd30);
        send(OP_CLEAR, 16'd0, 1'b0);
        send(OP_SAMPLE, 16'd100, 1'b0);
        fast = 1'b1;
        repeat (25) send(OP_TICK, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        fast = 1'b0;
        send(OP_SAMPLE, 16'd100, 1'b0);
        send(OP_CLEAR, 16'd0, 1'b0);
        send(OP_SAMPLE, 16'd0, 1'b0);
        send(OP_TICK, 16'd0, 1'b0);
        send(OP_SAMPLE, 16'd0, 1'b0);

        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d requests over %0d register settings, incl. a long hold run.",
                 sent_count, settings_used);
        $display("Compared %0d results; e-stop latched %0d times, pressure trip %0d times.",
                 results_checked, estop_count, trip_count);
        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> pressure_safety_interlock_top.f
design/psi_pkg.sv
design/psi_cfg_regs.sv
design/psi_core.sv
design/pressure_safety_interlock_top.sv
bench/psi_interlock_checker.sv
bench/tb_pressure_safety_interlock_top.sv
